// ===== src/sbpr_pkg.sv =====
// shared constants, phase encoding and interface structs for the servo bus packet receiver
// no dependencies
package sbpr_pkg;

    localparam int MAX_LEN       = 64;
    localparam int STORE_DEPTH   = MAX_LEN + 1;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int LEN_W         = 7;
    localparam int SYNC_OVERHEAD = 6;
    localparam int MIN_LEN       = 3;

    localparam logic [7:0] HEADER       = 8'hAA;
    localparam logic [7:0] SYNC_WRITE   = 8'h83;
    localparam logic [7:0] PWM_ADDR     = 8'h10;
    localparam logic [7:0] OWN_ID_RESET = 8'h01;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_LEN       = 4'd1,
        PH_BODY      = 4'd2,
        PH_PLAIN     = 4'd3,
        PH_SYNC_ADDR = 4'd4,
        PH_SYNC_LEN  = 4'd5,
        PH_ENTRY     = 4'd6,
        PH_DATA      = 4'd7,
        PH_CKSUM     = 4'd8
    } t_phase;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    typedef struct packed {
        logic             frame_go;
        logic [LEN_W-1:0] frame_len;
        logic             pwm_go;
        logic [15:0]      pwm_value;
    } t_parse_evt;

endpackage

// ===== src/sbpr_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module sbpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sbpr_parser.sv =====
// frame parser: header, length, body and sync-write entry tracking with checksum
// depends on sbpr_pkg; drives the frame store write port and frame / pwm events
module sbpr_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_strobe,
    input  logic [7:0]           i_byte,
    input  logic [7:0]           i_own_id,
    output sbpr_pkg::t_store_wr  o_store_wr,
    output sbpr_pkg::t_parse_evt o_evt
);
    import sbpr_pkg::*;

    t_phase           r_phase, n_phase, c_phase;
    logic [LEN_W-1:0] r_decl_len, n_decl_len, c_decl_len;
    logic [LEN_W-1:0] r_byte_idx, n_byte_idx, c_byte_idx;
    logic [7:0]       r_sum, n_sum, c_sum;
    logic [7:0]       r_entry_len, n_entry_len, c_entry_len;
    logic [7:0]       r_entry_cnt, n_entry_cnt, c_entry_cnt;
    logic [LEN_W-1:0] r_store_ptr, n_store_ptr, c_store_ptr;
    logic [LEN_W-1:0] r_timer, n_timer;
    logic [7:0]       r_start_addr;
    logic [7:0]       r_prev_byte;

    logic [7:0]       nb;
    logic             timeout;
    logic             entry_start;
    logic             len_bad;
    logic             entry_big;
    logic [LEN_W-1:0] idx_inc;
    logic [LEN_W-1:0] ptr_inc;
    logic [7:0]       sum_add;
    t_store_wr        wr;
    t_parse_evt       evt;

    assign nb      = ~i_byte;
    assign timeout = (r_timer == '0);

    always_comb begin
        if (timeout) begin
            c_phase     = PH_IDLE;
            c_decl_len  = '0;
            c_byte_idx  = '0;
            c_sum       = '0;
            c_entry_len = '0;
            c_entry_cnt = '0;
            c_store_ptr = '0;
        end else begin
            c_phase     = r_phase;
            c_decl_len  = r_decl_len;
            c_byte_idx  = r_byte_idx;
            c_sum       = r_sum;
            c_entry_len = r_entry_len;
            c_entry_cnt = r_entry_cnt;
            c_store_ptr = r_store_ptr;
        end
    end

    assign idx_inc     = c_byte_idx + 1'b1;
    assign ptr_inc     = (c_store_ptr < LEN_W'(STORE_DEPTH)) ? c_store_ptr + 1'b1 : c_store_ptr;
    assign sum_add     = c_sum + nb;
    assign entry_start = ({1'b0, c_entry_cnt} == ({1'b0, c_entry_len} + 9'd1));
    assign len_bad     = (i_byte > 8'(MAX_LEN)) || (i_byte < 8'(MIN_LEN));
    assign entry_big   = (({1'b0, i_byte} + 9'(SYNC_OVERHEAD)) > 9'(MAX_LEN));

    // next state
    always_comb begin
        n_phase     = c_phase;
        n_decl_len  = c_decl_len;
        n_byte_idx  = c_byte_idx;
        n_sum       = c_sum;
        n_entry_len = c_entry_len;
        n_entry_cnt = c_entry_cnt;
        n_store_ptr = c_store_ptr;
        n_timer     = timeout ? LEN_W'(MAX_LEN) : r_timer - 1'b1;
        unique case (c_phase)
            PH_LEN: begin
                n_byte_idx = '0;
                if (len_bad) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_decl_len = i_byte[LEN_W-1:0];
                    n_sum      = nb;
                    n_phase    = PH_BODY;
                end
            end
            PH_BODY: begin
                n_byte_idx = idx_inc;
                n_sum      = sum_add;
                if (idx_inc == LEN_W'(3)) begin
                    n_phase = (i_byte == SYNC_WRITE) ? PH_SYNC_ADDR : PH_PLAIN;
                end
            end
            PH_PLAIN, PH_CKSUM: begin
                if (c_byte_idx == c_decl_len) begin
                    n_phase     = PH_IDLE;
                    n_decl_len  = '0;
                    n_byte_idx  = '0;
                    n_sum       = '0;
                    n_entry_len = '0;
                    n_entry_cnt = '0;
                    n_store_ptr = '0;
                end else begin
                    n_sum      = sum_add;
                    n_byte_idx = idx_inc;
                end
            end
            PH_SYNC_ADDR: begin
                n_sum      = sum_add;
                n_byte_idx = idx_inc;
                n_phase    = PH_SYNC_LEN;
            end
            PH_SYNC_LEN: begin
                if (entry_big) begin
                    n_phase     = PH_IDLE;
                    n_decl_len  = '0;
                    n_byte_idx  = '0;
                    n_sum       = '0;
                    n_entry_len = '0;
                    n_entry_cnt = '0;
                    n_store_ptr = '0;
                end else begin
                    n_entry_len = i_byte;
                    n_byte_idx  = idx_inc;
                    n_sum       = sum_add;
                    n_entry_cnt = i_byte + 8'd1;
                    n_store_ptr = idx_inc;
                    n_phase     = PH_ENTRY;
                end
            end
            PH_ENTRY: begin
                if (entry_start && (c_byte_idx == c_decl_len)) begin
                    n_phase     = PH_IDLE;
                    n_decl_len  = '0;
                    n_byte_idx  = '0;
                    n_sum       = '0;
                    n_entry_len = '0;
                    n_entry_cnt = '0;
                    n_store_ptr = '0;
                end else begin
                    if (entry_start) begin
                        n_entry_cnt = 8'd1;
                        if (i_byte == i_own_id) begin
                            n_store_ptr = ptr_inc;
                            n_phase     = PH_DATA;
                        end
                    end else begin
                        n_entry_cnt = c_entry_cnt + 8'd1;
                    end
                    n_sum      = sum_add;
                    n_byte_idx = idx_inc;
                end
            end
            PH_DATA: begin
                n_store_ptr = ptr_inc;
                n_sum       = sum_add;
                n_byte_idx  = idx_inc;
                n_entry_cnt = c_entry_cnt + 8'd1;
                if (c_entry_cnt == c_entry_len) begin
                    n_phase = PH_CKSUM;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_byte == HEADER) begin
                    n_phase = PH_LEN;
                    n_timer = LEN_W'(MAX_LEN);
                end
            end
        endcase
    end

    // store writes and events
    always_comb begin
        logic [LEN_W-1:0] wr_idx;
        wr_idx         = c_byte_idx;
        wr.en          = 1'b0;
        evt.frame_go   = 1'b0;
        evt.frame_len  = c_decl_len;
        evt.pwm_go     = 1'b0;
        evt.pwm_value  = {i_byte, r_prev_byte};
        unique case (c_phase)
            PH_BODY, PH_SYNC_ADDR: begin
                wr.en = 1'b1;
            end
            PH_PLAIN: begin
                wr.en = 1'b1;
                if ((c_byte_idx == c_decl_len) && (c_sum == i_byte)) begin
                    evt.frame_go = 1'b1;
                end
            end
            PH_SYNC_LEN: begin
                wr.en = !entry_big;
            end
            PH_ENTRY: begin
                wr_idx = c_store_ptr;
                wr.en  = entry_start && (c_byte_idx != c_decl_len) && (i_byte == i_own_id);
            end
            PH_DATA: begin
                wr_idx = c_store_ptr;
                wr.en  = 1'b1;
                if ((c_entry_cnt == c_entry_len) && (r_start_addr == PWM_ADDR)) begin
                    evt.pwm_go = 1'b1;
                end
            end
            PH_CKSUM: begin
                evt.frame_len = c_entry_len[LEN_W-1:0] + LEN_W'(SYNC_OVERHEAD);
                if ((c_byte_idx == c_decl_len) && (c_sum == i_byte) &&
                    (r_start_addr != PWM_ADDR)) begin
                    evt.frame_go = 1'b1;
                end
            end
            default: begin
                wr.en = 1'b0;
            end
        endcase
        wr.en        = wr.en && i_strobe && (wr_idx < LEN_W'(STORE_DEPTH));
        wr.addr      = STORE_AW'(wr_idx);
        wr.data      = i_byte;
        evt.frame_go = evt.frame_go && i_strobe;
        evt.pwm_go   = evt.pwm_go && i_strobe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_decl_len  <= '0;
            r_byte_idx  <= '0;
            r_sum       <= '0;
            r_entry_len <= '0;
            r_entry_cnt <= '0;
            r_store_ptr <= '0;
            r_timer     <= LEN_W'(MAX_LEN);
        end else if (i_strobe) begin
            r_phase     <= n_phase;
            r_decl_len  <= n_decl_len;
            r_byte_idx  <= n_byte_idx;
            r_sum       <= n_sum;
            r_entry_len <= n_entry_len;
            r_entry_cnt <= n_entry_cnt;
            r_store_ptr <= n_store_ptr;
            r_timer     <= n_timer;
        end
    end

    // shadow of store entry 3 and the previous byte
    always_ff @(posedge i_clk) begin
        if (wr.en && (wr.addr == STORE_AW'(3))) begin
            r_start_addr <= i_byte;
        end
        if (i_strobe) begin
            r_prev_byte <= i_byte;
        end
    end

    assign o_store_wr = wr;
    assign o_evt      = evt;

endmodule

// ===== src/servo_bus_packet_receiver_top.sv =====
// servo bus packet receiver: parser, frame store ram, frame emitter and output register
// depends on sbpr_pkg, sbpr_ram, sbpr_parser
// a pwm update reaches the output register in the cycle after its byte transfer
// frame bytes start once the checksum byte has set the emitter busy and follow as
// one store read, then one output load per byte; input stalls until the last byte is loaded
// throughput: one input byte per cycle outside frame emission and output stall
// reset: sync active low; clears parser, emitter and output valid; reloads timer; own_id to 1;
// the frame store is not cleared and needs no clearing pass
module servo_bus_packet_receiver_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [7:0]                  i_rx_byte,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [7:0]                  i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_kind,
    output logic [7:0]                  o_body_byte,
    output logic                        o_last,
    output logic [sbpr_pkg::LEN_W-1:0]  o_frame_length,
    output logic [15:0]                 o_pwm_value
);
    import sbpr_pkg::*;

    logic [7:0]       r_own_id;
    logic             r_emit_busy;
    logic             r_rd_pend;
    logic [LEN_W-1:0] r_emit_idx;
    logic [LEN_W-1:0] r_emit_len;
    logic             r_out_valid;
    logic             r_kind;
    logic [7:0]       r_body_byte;
    logic             r_last;
    logic [LEN_W-1:0] r_frame_length;
    logic [15:0]      r_pwm_value;

    logic             in_xfer;
    logic             out_free;
    logic             rd_issue;
    logic             emit_load;
    logic             emit_last;
    logic [7:0]       rd_data;
    t_store_wr        store_wr;
    t_parse_evt       evt;

    assign o_in_stall  = r_emit_busy || (r_out_valid && i_out_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= OWN_ID_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_id <= i_cfg_data;
        end
    end

    sbpr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_strobe   (in_xfer),
        .i_byte     (i_rx_byte),
        .i_own_id   (r_own_id),
        .o_store_wr (store_wr),
        .o_evt      (evt)
    );

    assign rd_issue  = r_emit_busy && !r_rd_pend;
    assign emit_load = r_rd_pend && out_free;
    assign emit_last = ((r_emit_idx + 1'b1) == r_emit_len);

    sbpr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (store_wr.en),
        .i_wr_addr (store_wr.addr),
        .i_wr_data (store_wr.data),
        .i_rd_en   (rd_issue),
        .i_rd_addr (STORE_AW'(r_emit_idx)),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_busy <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_emit_idx  <= '0;
            r_emit_len  <= '0;
        end else if (evt.frame_go) begin
            r_emit_busy <= 1'b1;
            r_rd_pend   <= 1'b0;
            r_emit_idx  <= '0;
            r_emit_len  <= evt.frame_len;
        end else if (rd_issue) begin
            r_rd_pend <= 1'b1;
        end else if (emit_load) begin
            r_rd_pend  <= 1'b0;
            r_emit_idx <= r_emit_idx + 1'b1;
            if (emit_last) begin
                r_emit_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (evt.pwm_go || emit_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (evt.pwm_go) begin
            r_kind         <= 1'b1;
            r_body_byte    <= 8'd0;
            r_last         <= 1'b1;
            r_frame_length <= '0;
            r_pwm_value    <= evt.pwm_value;
        end else if (emit_load) begin
            r_kind         <= 1'b0;
            r_body_byte    <= rd_data;
            r_last         <= emit_last;
            r_frame_length <= r_emit_len;
            r_pwm_value    <= 16'd0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_body_byte    = r_body_byte;
    assign o_last         = r_last;
    assign o_frame_length = r_frame_length;
    assign o_pwm_value    = r_pwm_value;

endmodule

// ===== src/sbpr_checker.sv =====
// port-level checks for the servo bus packet receiver, bound to the top level
// depends on sbpr_pkg and servo_bus_packet_receiver_top
module sbpr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_kind,
    input logic [7:0]                 o_body_byte,
    input logic                       o_last,
    input logic [sbpr_pkg::LEN_W-1:0] o_frame_length,
    input logic [15:0]                o_pwm_value
);
    import sbpr_pkg::*;

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_body_byte) && $stable(o_kind) &&
            $stable(o_last) && $stable(o_pwm_value))
        else $error("output payload changed while stalled");

    // input held off while a frame is still being emitted
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind && !o_last |-> o_in_stall)
        else $error("input open in the middle of a frame");

    a_pwm_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind |-> o_last && (o_body_byte == 8'd0) && (o_frame_length == '0))
        else $error("malformed pwm update");

    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_kind |-> (o_frame_length >= LEN_W'(MIN_LEN)) &&
            (o_frame_length <= LEN_W'(MAX_LEN)) && (o_pwm_value == 16'd0))
        else $error("malformed frame byte");

endmodule

bind servo_bus_packet_receiver_top sbpr_checker u_sbpr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_kind         (o_kind),
    .o_body_byte    (o_body_byte),
    .o_last         (o_last),
    .o_frame_length (o_frame_length),
    .o_pwm_value    (o_pwm_value)
);
